/* sv/assert_macros.svh */
// Assertion helpers for the wind lattice sampler.
// Each macro takes a label, a condition, a consequence and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_SAME(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define CHK_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define CHK_SAME(lbl, a, b, msg)
`define CHK_NEXT(lbl, a, b, msg)
`endif
`endif

/* sv/wlbs_pkg.sv */
//------------------------------------------------------------------------------
// wlbs_pkg
// Types, constants and helpers shared by the wind lattice sampler modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package wlbs_pkg;

  localparam int GRID     = 16;
  localparam int CELLS    = GRID * GRID;
  localparam int ADDR_W   = 8;
  localparam int COORD_W  = 4;
  localparam int DIV_W    = 38;
  localparam int DVS_W    = 13;
  localparam int QDEPTH   = 2;

  localparam logic signed [15:0] RESET_CELL = 16'sd128;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_PLAIN   = 2'd1,
    OP_FRACTAL = 2'd2
  } op_t;

  typedef struct packed {
    logic        enable;
    logic [12:0] width;
    logic [15:0] gain;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [1:0]         octaves;
    logic [7:0]         cell_index;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOC,
    S_LOC_WAIT,
    S_RD_ADDR,
    S_RD_WAIT,
    S_RD_ACC,
    S_ROUND,
    S_SCALE,
    S_PLAIN,
    S_FMAG,
    S_FMUL,
    S_FDIVST,
    S_FDIV
  } state_t;

  // Position times the octave scale; negative positions become zero.
  function automatic logic [25:0] scale_pos(input logic signed [23:0] pos,
                                            input logic [1:0] k);
    logic signed [26:0] p;
    p = 27'(pos) <<< k;
    return p[26] ? 26'd0 : p[25:0];
  endfunction

  // Fractal divisor: 16 minus 8 shifted right by the octave count.
  function automatic logic [DVS_W-1:0] frac_div(input logic [1:0] oct);
    logic [4:0] d;
    d = 5'd16 - (5'd8 >> oct);
    return DVS_W'(d);
  endfunction

  function automatic logic [15:0] sat16(input logic neg, input logic [DIV_W-1:0] mag);
    logic [15:0] r;
    if (neg) begin
      if (mag > DIV_W'(32768)) r = 16'h8000;
      else r = ~mag[15:0] + 16'd1;
    end else begin
      if (mag > DIV_W'(32767)) r = 16'h7fff;
      else r = mag[15:0];
    end
    return r;
  endfunction

endpackage

/* sv/wlbs_ram.sv */
//------------------------------------------------------------------------------
// wlbs_ram
// Generic single-port RAM with a registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

/* sv/wlbs_div.sv */
//------------------------------------------------------------------------------
// wlbs_div
// Two-lane restoring divider with a shared divisor, one quotient bit a cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlbs_div
  import wlbs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0][DIV_W-1:0]      dividend,
  input  logic [DVS_W-1:0]           divisor,
  output logic                       busy,
  output logic                       done,
  output logic [1:0][DIV_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem [2];
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   rsh [2];

  always_comb begin
    for (int l = 0; l < 2; l++) rsh[l] = {rem[l], quotient[l][DIV_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int l = 0; l < 2; l++) begin
        rem[l]      <= '0;
        quotient[l] <= dividend[l];
      end
    end else if (busy) begin
      for (int l = 0; l < 2; l++) begin
        if (rsh[l] >= {1'b0, dvs}) begin
          rem[l]      <= DVS_W'(rsh[l] - {1'b0, dvs});
          quotient[l] <= {quotient[l][DIV_W-2:0], 1'b1};
        end else begin
          rem[l]      <= rsh[l][DVS_W-1:0];
          quotient[l] <= {quotient[l][DIV_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

/* sv/wlbs_front.sv */
//------------------------------------------------------------------------------
// wlbs_front
// Accepts input words, decodes the operation and queues commands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlbs_front
  import wlbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  output cmd_t        q_cmd,
  output logic        q_valid,
  input  logic        q_pop
);

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             accept, known, push;
  cmd_t             cmd_in;

  assign s_axis_tready = (count != (PTR_W+1)'(QDEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign q_cmd         = slots[rd_ptr];

  always_comb begin
    known = 1'b1;
    cmd_in.op = OP_WRITE;
    unique case (s_axis_tuser)
      OP_WRITE:   cmd_in.op = OP_WRITE;
      OP_PLAIN:   cmd_in.op = OP_PLAIN;
      OP_FRACTAL: cmd_in.op = OP_FRACTAL;
      default:    known = 1'b0;
    endcase
    cmd_in.pos_x      = s_axis_tdata[23:0];
    cmd_in.pos_y      = s_axis_tdata[47:24];
    cmd_in.octaves    = s_axis_tdata[49:48];
    cmd_in.cell_index = s_axis_tdata[57:50];
    cmd_in.vel_x      = s_axis_tdata[73:58];
    cmd_in.vel_y      = s_axis_tdata[89:74];
  end

  // The unused operation is taken and dropped here.
  assign push = accept && known;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      if (q_pop) rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cmd_in;
  end

endmodule

/* sv/wlbs_back.sv */
//------------------------------------------------------------------------------
// wlbs_back
// Executes queued commands: lattice writes, plain and fractal sampling.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wlbs_back
  import wlbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        q_cmd,
  input  logic        q_valid,
  output logic        q_pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata
);

  state_t state, state_next;

  cmd_t               cur;
  logic [1:0]         k, n;
  logic [COORD_W-1:0] ci, cj;
  logic [15:0]        fx, fy;
  logic               on_border;
  logic [33:0]        wgt;
  logic [CELLS-1:0]   valid;
  logic               valid_q;
  logic signed [50:0] prod [2];
  logic signed [50:0] acc  [2];
  logic signed [23:0] s    [2];
  logic signed [27:0] facc [2];
  logic [43:0]        m1   [2];
  logic [37:0]        m2lo [2];
  logic [37:0]        m2hi [2];
  logic               fneg [2];

  logic                  do_write, do_query;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr, rd_addr;
  logic [31:0]           ram_rdata;
  logic                  div_start, div_busy, div_done;
  logic [1:0][DIV_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0]      div_dvs;
  logic [19:0]           t [2];
  logic [16:0]           wxs, wys;
  logic signed [15:0]    cval [2];
  logic signed [23:0]    s_rnd [2];
  logic [15:0]           v_plain [2];
  logic [60:0]           ftot [2];

  assign do_write = (state == S_IDLE) && q_valid && (q_cmd.op == OP_WRITE);
  assign do_query = (state == S_IDLE) && q_valid && (q_cmd.op != OP_WRITE) && !m_axis_tvalid;
  assign q_pop    = do_write || do_query;
  assign ram_we   = do_write && ({1'b0, q_cmd.cell_index} < 9'(CELLS));
  assign rd_addr  = {COORD_W'(cj + {3'b0, n[1]}), COORD_W'(ci + {3'b0, n[0]})};
  assign ram_addr = (state == S_IDLE) ? q_cmd.cell_index : rd_addr;
  assign wxs      = n[0] ? {1'b0, fx} : 17'(17'h10000 - {1'b0, fx});
  assign wys      = n[1] ? {1'b0, fy} : 17'(17'h10000 - {1'b0, fy});

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [50:0] mg;
      logic [50:0] rq;
      logic [50:0] pm;
      logic [50:0] pq;
      t[l]    = (cfg.width == '0) ? 20'd0 : div_q[l][19:0];
      cval[l] = valid_q ? ram_rdata[16*l +: 16] : RESET_CELL;
      mg      = acc[l][50] ? 51'(-acc[l]) : 51'(acc[l]);
      rq      = (mg + 51'(24'h800000)) >> 24;
      s_rnd[l] = acc[l][50] ? 24'(-rq[23:0]) : rq[23:0];
      pm      = prod[l][50] ? 51'(-prod[l]) : 51'(prod[l]);
      pq      = (pm + 51'(16'h8000)) >> 16;
      v_plain[l] = sat16(prod[l][50], pq[DIV_W-1:0]);
      ftot[l] = 61'({m2hi[l], 22'b0}) + 61'(m2lo[l])
              + (61'(frac_div(cur.octaves)) << 23);
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_dvs    = cfg.width;
    div_dvd[0] = {scale_pos(cur.pos_x, k), 12'b0};
    div_dvd[1] = {scale_pos(cur.pos_y, k), 12'b0};
    unique case (state)
      S_IDLE:     if (do_query && cfg.enable) state_next = S_LOC;
      S_LOC: begin
        div_start  = 1'b1;
        state_next = S_LOC_WAIT;
      end
      S_LOC_WAIT: if (div_done) state_next = S_RD_ADDR;
      S_RD_ADDR:  state_next = S_RD_WAIT;
      S_RD_WAIT:  state_next = on_border ? S_SCALE : S_RD_ACC;
      S_RD_ACC:   state_next = (n == 2'd3) ? S_ROUND : S_RD_ADDR;
      S_ROUND:    state_next = S_SCALE;
      S_SCALE: begin
        if (cur.op == OP_PLAIN) state_next = S_PLAIN;
        else if (k == cur.octaves) state_next = S_FMAG;
        else state_next = S_LOC;
      end
      S_PLAIN:    state_next = S_IDLE;
      S_FMAG:     state_next = S_FMUL;
      S_FMUL:     state_next = S_FDIVST;
      S_FDIVST: begin
        div_start  = 1'b1;
        div_dvs    = frac_div(cur.octaves);
        div_dvd[0] = {1'b0, ftot[0][60:24]};
        div_dvd[1] = {1'b0, ftot[1][60:24]};
        state_next = S_FDIV;
      end
      S_FDIV:     if (div_done) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (ram_we) valid[q_cmd.cell_index] <= 1'b1;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if ((do_query && !cfg.enable) || state == S_PLAIN || (state == S_FDIV && div_done))
        m_axis_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      cur <= q_cmd;
      k   <= 2'd0;
      for (int l = 0; l < 2; l++) facc[l] <= '0;
      if (!cfg.enable) m_axis_tdata <= '0;
    end
    unique case (state)
      S_LOC_WAIT: if (div_done) begin
        ci        <= t[0][19:16];
        fx        <= t[0][15:0];
        cj        <= t[1][19:16];
        fy        <= t[1][15:0];
        on_border <= (t[0][19:16] == COORD_W'(GRID - 1)) ||
                     (t[1][19:16] == COORD_W'(GRID - 1));
        n         <= 2'd0;
        for (int l = 0; l < 2; l++) acc[l] <= '0;
      end
      S_RD_ADDR: begin
        wgt     <= 34'(wxs * wys);
        valid_q <= valid[rd_addr];
      end
      S_RD_WAIT: begin
        for (int l = 0; l < 2; l++) begin
          if (on_border) s[l] <= {cval[l], 8'b0};
          else prod[l] <= 51'(cval[l] * $signed({1'b0, wgt}));
        end
      end
      S_RD_ACC: begin
        for (int l = 0; l < 2; l++) acc[l] <= acc[l] + prod[l];
        n <= n + 2'd1;
      end
      S_ROUND: for (int l = 0; l < 2; l++) s[l] <= s_rnd[l];
      S_SCALE: begin
        for (int l = 0; l < 2; l++) begin
          prod[l] <= 51'(s[l] * $signed({1'b0, cfg.gain}));
          facc[l] <= facc[l] + (28'(s[l]) <<< (2'd3 - k));
        end
        k <= k + 2'd1;
      end
      S_PLAIN: m_axis_tdata <= {v_plain[1], v_plain[0]};
      S_FMAG: begin
        for (int l = 0; l < 2; l++) begin
          fneg[l] <= facc[l][27];
          m1[l]   <= 44'((facc[l][27] ? 28'(-facc[l]) : 28'(facc[l])) * cfg.gain);
        end
      end
      S_FMUL: begin
        for (int l = 0; l < 2; l++) begin
          m2lo[l] <= 38'(m1[l][21:0] * cfg.gain);
          m2hi[l] <= 38'(m1[l][43:22] * cfg.gain);
        end
      end
      S_FDIV: if (div_done)
        m_axis_tdata <= {sat16(fneg[1], div_q[1]), sat16(fneg[0], div_q[0])};
      default: ;
    endcase
  end

  wlbs_ram #(
    .WIDTH(32),
    .DEPTH(CELLS)
  ) u_lattice (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({q_cmd.vel_y, q_cmd.vel_x}),
    .rdata (ram_rdata)
  );

  wlbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  `CHK_SAME(a_div_idle, div_start, !div_busy, "divider started while busy")
  `CHK_SAME(a_pop_valid, q_pop, q_valid, "queue popped while empty")
  `CHK_SAME(a_out_free, state == S_PLAIN || state == S_FDIV, !m_axis_tvalid,
            "result produced while output word still pending")
  `CHK_NEXT(a_rd_seq, state == S_RD_ADDR, state == S_RD_WAIT, "lattice read out of sequence")

endmodule

/* sv/wind_lattice_bilinear_sampler.sv */
//------------------------------------------------------------------------------
// wind_lattice_bilinear_sampler
// Two 16x16 wind lattices sampled bilinearly, with plain and fractal queries.
//------------------------------------------------------------------------------
// Channel   Direction  Handshake              Content
// s_axis    in         tvalid/tready          operation (tuser) and payload word
// m_axis    out        tvalid/tready          sampled velocity word
// cfg       in         cfg_we, no wait        enable, region width, gain
//
// A lattice write is done by the back end in its idle state, and so is a disabled
// query. A plain query runs from its pop to the output word as follows: the
// 38-step shared divider locates the cell, then come four lattice reads, rounding
// and gain. A cell on the last row or column needs one read. A fractal query
// repeats the location and reads once per octave and ends with a final pass
// through the same divider.
// Reset is synchronous; lattice cells read 0.5 until written through per-cell
// valid bits that reset clears at once, so there is no clearing pass.
// A two-word queue lets input words arrive while the back end works or a
// result waits on the output register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wind_lattice_bilinear_sampler
  import wlbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[23:0], pos_y[47:24], octaves[49:48], cell_index[57:50],
  // cell_vel_x[73:58], cell_vel_y[89:74], zero fill[95:90]
  input  logic [95:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vel_x[15:0], vel_y[31:16]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  cmd_t q_cmd;
  logic q_valid, q_pop;

  // Configuration registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.width  <= 13'd256;
      cfg.gain   <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: cfg.enable <= cfg_data[0];
        REG_WIDTH:  cfg.width  <= cfg_data[12:0];
        REG_GAIN:   cfg.gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  wlbs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_cmd         (q_cmd),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  wlbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_cmd         (q_cmd),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* test/wind_lattice_bilinear_sampler_chk.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Wind lattice sampler checker
// Watches the input, output and register ports. It keeps its own lattices and
// registers, predicts each query's velocity and compares it with the result.
//------------------------------------------------------------------------------

module wind_lattice_bilinear_sampler_chk
  import wlbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          failures
);

  typedef struct {
    logic [15:0] vx;
    logic [15:0] vy;
  } vel_t;

  logic signed [15:0] wind_x [CELLS];
  logic signed [15:0] wind_y [CELLS];
  logic        on;
  logic [12:0] span;
  logic [15:0] gain;
  vel_t        due_vel [$];

  function automatic longint round_q(longint n, longint unsigned d);
    longint unsigned mag;
    longint unsigned q;
    mag = (n < 0) ? longint'(-n) : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Maps a Q.8 position onto a lattice coordinate and a Q0.16 fraction.
  function automatic void place(longint p, output int idx, output int unsigned frac);
    longint unsigned w;
    longint unsigned up;
    longint unsigned t;
    w = span;
    up = (w == 0 || p < 0) ? 0 : p;
    if (w == 0) begin
      idx = 0;
      frac = 0;
    end else begin
      if (up >= (w << 8)) up = up % (w << 8);
      t = ((up * GRID) << 8) / w;
      idx = int'(t >> 16);
      frac = int'(t & 64'hFFFF);
    end
  endfunction

  function automatic longint blend(logic ax, int i, int j, int unsigned dx,
                                   int unsigned dy);
    int k;
    longint w0x;
    longint w0y;
    longint c00, c10, c01, c11;
    longint s;
    if (i >= GRID) i = GRID - 1;
    if (j >= GRID) j = GRID - 1;
    k = i + j * GRID;
    c00 = ax ? wind_y[k] : wind_x[k];
    if (i >= GRID - 1 || j >= GRID - 1) return c00 * 256;
    c10 = ax ? wind_y[k + 1] : wind_x[k + 1];
    c01 = ax ? wind_y[k + GRID] : wind_x[k + GRID];
    c11 = ax ? wind_y[k + GRID + 1] : wind_x[k + GRID + 1];
    w0x = 65536 - longint'(dx);
    w0y = 65536 - longint'(dy);
    s = c00 * (w0x * w0y) + c10 * (longint'(dx) * w0y)
      + c01 * (w0x * longint'(dy)) + c11 * (longint'(dx) * longint'(dy));
    return round_q(s, 64'd1 << 24);
  endfunction

  function automatic vel_t wind_at(logic [1:0] op, longint px, longint py,
                                   logic [1:0] oct);
    vel_t r;
    int i, j;
    int unsigned dx, dy;
    longint ax, ay, g, d;
    g = gain;
    ax = 0;
    ay = 0;
    r.vx = '0;
    r.vy = '0;
    if (!on) return r;
    for (int k = 0; k <= ((op == OP_PLAIN) ? 0 : oct); k++) begin
      d = 64'sd1 << k;
      place(px * d, i, dx);
      place(py * d, j, dy);
      ax += blend(1'b0, i, j, dx, dy) * (8 >> k);
      ay += blend(1'b1, i, j, dx, dy) * (8 >> k);
    end
    if (op == OP_PLAIN) begin
      r.vx = clip16(round_q(ax / 8 * g, 65536));
      r.vy = clip16(round_q(ay / 8 * g, 65536));
    end else begin
      d = (16 - (8 >> oct)) * (64'sd1 << 24);
      r.vx = clip16(round_q(ax * g * g, d));
      r.vy = clip16(round_q(ay * g * g, d));
    end
    return r;
  endfunction

  assign pending = due_vel.size();

  always @(posedge clk) begin
    vel_t e;
    logic [15:0] gx, gy;
    if (rst) begin
      for (int n = 0; n < CELLS; n++) begin
        wind_x[n] = RESET_CELL;
        wind_y[n] = RESET_CELL;
      end
      on = 1'b0;
      span = 13'd256;
      gain = 16'd256;
      due_vel.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ENABLE) on = cfg_data[0];
        else if (cfg_index == REG_WIDTH) span = cfg_data[12:0];
        else if (cfg_index == REG_GAIN) gain = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_WRITE) begin
          wind_x[s_axis_tdata[57:50]] = s_axis_tdata[73:58];
          wind_y[s_axis_tdata[57:50]] = s_axis_tdata[89:74];
        end else if (s_axis_tuser == OP_PLAIN || s_axis_tuser == OP_FRACTAL) begin
          due_vel.push_back(wind_at(s_axis_tuser,
                                    longint'($signed(s_axis_tdata[23:0])),
                                    longint'($signed(s_axis_tdata[47:24])),
                                    s_axis_tdata[49:48]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        gx = m_axis_tdata[15:0];
        gy = m_axis_tdata[31:16];
        if (due_vel.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result word vel_x=%h vel_y=%h", gx, gy);
        end else begin
          e = due_vel.pop_front();
          if (e.vx !== gx || e.vy !== gy) begin
            failures++;
            if (failures <= 10)
              $display("velocity mismatch: expected %h/%h, got %h/%h",
                       e.vx, e.vy, gx, gy);
          end
        end
      end
    end
  end

  final begin
  end

endmodule

/* test/wind_lattice_bilinear_sampler_tb.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Wind lattice sampler testbench
// Drives lattice writes and plain and fractal queries through several register
// settings and idling patterns; a separate checker predicts every word.
//------------------------------------------------------------------------------

module wind_lattice_bilinear_sampler_tb;
  import wlbs_pkg::*;

  // The op code that the block ignores.
  localparam logic [1:0] OP_IGNORED = 2'd3;
  // Cycles with no word moving on either side before the run is abandoned.
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          pending;
  int          failures;

  int src_idle_pct;
  int sink_stall_pct;
  int hold_off;
  int quiet_cycles;
  logic [12:0] cur_span;

  wind_lattice_bilinear_sampler dut (.*);

  wind_lattice_bilinear_sampler_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stalls at random, or holds off for a long stretch on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        hold_off--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog on progress of either channel.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("wind_lattice_bilinear_sampler_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one word and returns at the edge where it is taken.
  task automatic send_word(logic [1:0] op, logic [23:0] px, logic [23:0] py,
                           logic [1:0] oct, logic [7:0] cidx, logic [15:0] vx,
                           logic [15:0] vy);
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, vy, vx, cidx, oct, py, px};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // Lattice writes queued behind the last query still have to finish.
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) cur_span = val[12:0];
  endtask

  // Position mostly near the region, so wrap and clamp both show up often.
  function automatic logic [23:0] pick_pos();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return 24'($urandom_range(cur_span * 256 - 1));
    if (r == 6) return 24'($urandom_range(cur_span * 1024));
    if (r == 7) return -24'($urandom_range(cur_span * 256));
    return 24'($urandom);
  endfunction

  task automatic random_words(int count);
    int unsigned r;
    logic [15:0] vx, vy;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      vx = 16'($urandom);
      vy = 16'($urandom);
      if ($urandom_range(9) == 0) vx = $urandom_range(1) ? 16'h7fff : 16'h8000;
      if ($urandom_range(9) == 0) vy = $urandom_range(1) ? 16'h7fff : 16'h8000;
      if (r < 30)
        send_word(OP_WRITE, 24'($urandom), 24'($urandom), 2'($urandom),
                  8'($urandom), vx, vy);
      else if (r < 62)
        send_word(OP_PLAIN, pick_pos(), pick_pos(), 2'($urandom), 8'($urandom), vx, vy);
      else if (r < 95)
        send_word(OP_FRACTAL, pick_pos(), pick_pos(), 2'($urandom), 8'($urandom), vx, vy);
      else
        send_word(OP_IGNORED, 24'($urandom), 24'($urandom), 2'($urandom),
                  8'($urandom), vx, vy);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_WRITE;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_off = 0;
    cur_span = 13'd256;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Queries while disabled answer zero; writes still land.
    send_word(OP_PLAIN, 24'd0, 24'd0, 2'd0, 8'd0, 16'd0, 16'd0);
    send_word(OP_WRITE, 24'd0, 24'd0, 2'd0, 8'd0, 16'h7fff, 16'h8000);
    send_word(OP_FRACTAL, 24'h7fffff, 24'h800000, 2'd3, 8'd0, 16'd0, 16'd0);
    go_quiet();
    write_reg(REG_ENABLE, 16'd1);

    // Directed: extreme cells, positions, octaves and the ignored op.
    send_word(OP_WRITE, 24'd0, 24'd0, 2'd0, 8'd255, 16'h8000, 16'h7fff);
    send_word(OP_WRITE, 24'd0, 24'd0, 2'd0, 8'd17, 16'hff00, 16'h0100);
    send_word(OP_IGNORED, 24'hffffff, 24'hffffff, 2'd3, 8'd1, 16'h1234, 16'h5678);
    send_word(OP_PLAIN, 24'd0, 24'd0, 2'd0, 8'd0, 16'd0, 16'd0);
    send_word(OP_PLAIN, 24'd128, 24'd384, 2'd0, 8'd0, 16'd0, 16'd0);
    send_word(OP_PLAIN, 24'hffffff, 24'h800000, 2'd0, 8'd0, 16'd0, 16'd0);
    send_word(OP_PLAIN, 24'h7fffff, 24'h7fffff, 2'd0, 8'd0, 16'd0, 16'd0);
    send_word(OP_PLAIN, 24'd65536, 24'd65535, 2'd0, 8'd0, 16'd0, 16'd0);
    send_word(OP_PLAIN, 24'd65535, 24'd100, 2'd0, 8'd0, 16'd0, 16'd0);
    send_word(OP_PLAIN, 24'd61440, 24'd61440, 2'd0, 8'd0, 16'd0, 16'd0);
    for (int o = 0; o < 4; o++)
      send_word(OP_FRACTAL, 24'(5000 + o * 777), 24'd300, 2'(o), 8'd0, 16'd0, 16'd0);
    send_word(OP_FRACTAL, 24'h7fffff, 24'h800000, 2'd3, 8'd0, 16'd0, 16'd0);
    go_quiet();

    // Phases: each a register setting and an idling pattern.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_WIDTH, 16'd256);
          write_reg(REG_GAIN, 16'd256);
        end
        1: begin
          write_reg(REG_WIDTH, 16'd16);
          write_reg(REG_GAIN, 16'hffff);
        end
        2: begin
          write_reg(REG_WIDTH, 16'd4096);
          write_reg(REG_GAIN, 16'd0);
        end
        3: begin
          write_reg(REG_WIDTH, 16'($urandom_range(16, 4096)));
          write_reg(REG_GAIN, 16'($urandom_range(0, 1024)));
        end
        4: begin
          write_reg(REG_ENABLE, 16'd0);
        end
        default: begin
          write_reg(REG_ENABLE, 16'd1);
          write_reg(REG_WIDTH, 16'($urandom_range(16, 600)));
          write_reg(REG_GAIN, 16'($urandom));
        end
      endcase
      src_idle_pct   = (ph % 4 == 1) ? 69 : (ph % 4 == 3) ? 31 : 0;
      sink_stall_pct = (ph % 4 == 2) ? 69 : (ph % 4 == 3) ? 31 : 0;
      // A long output hold-off so the input queue fills and backs up.
      if (ph == 2) hold_off = 3000;
      random_words(270);
      go_quiet();
    end

    repeat (300) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("wind_lattice_bilinear_sampler_tb: clean");
    end else begin
      $display("wind_lattice_bilinear_sampler_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/wlbs_pkg.sv
sv/wlbs_ram.sv
sv/wlbs_div.sv
sv/wlbs_front.sv
sv/wlbs_back.sv
sv/wind_lattice_bilinear_sampler.sv
test/wind_lattice_bilinear_sampler_chk.sv
test/wind_lattice_bilinear_sampler_tb.sv
